[rtl/core/spnb_pkg.sv]
package spnb_pkg;

  // Field widths of the pixel transactions and of the register port.
  localparam int WS_W       = 48;
  localparam int W_W        = 32;
  localparam int BG_W       = 24;
  localparam int PIX_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Internal formats: average is Q.8 with 40 bits, foreground weight Q0.16,
  // blended value Q.24 with 56 bits.
  localparam int W_FRAC = 16;
  localparam int AVG_W  = 40;
  localparam int FG_W   = 16;
  localparam int R_W    = 56;
  localparam int AVG_LO = AVG_W - W_FRAC;

  // Quotient bits resolved by one divider stage.
  localparam int DIV_BPS = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_ENABLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_DENOMINATOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE_SELECT = 2'd2;

  localparam logic [W_W-1:0] BLEND_DEN_RESET = 32'h0001_0000;

  // Full scale thresholds in Q.24: 65535 and 255.
  localparam logic [R_W-1:0] TOP_16 = 56'h0000_FFFF_00_0000;
  localparam logic [R_W-1:0] TOP_8  = 56'h0000_00FF_00_0000;

  // Rounding: add one half in Q.24, keep bits 39..24.
  localparam int               RND_W      = 41;
  localparam int               OUT_LO     = 24;
  localparam logic [RND_W-1:0] ROUND_HALF = 41'h000_0080_0000;
  localparam logic [PIX_W-1:0] PIX_MAX    = 16'hFFFF;

endpackage

[rtl/core/spnb_if.sv]
// Input channel: one pixel's accumulated values per transaction.
interface spnb_in_if import spnb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [WS_W-1:0] weighted_sum;
  logic [W_W-1:0]  weight_sum;
  logic [BG_W-1:0] background;

  modport source (output valid, output weighted_sum, output weight_sum,
                  output background, input ready);
  modport sink   (input valid, input weighted_sum, input weight_sum,
                  input background, output ready);
endinterface

// Output channel: one finished pixel per transaction.
interface spnb_out_if import spnb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

[rtl/core/spnb_div_pipe.sv]
// Pipelined restoring divider. Each stage resolves BPS quotient bits.
// The caller supplies a starting remainder that is below the divisor; the
// numerator bits still to be brought down share one register with the
// quotient bits already produced. A sideband vector travels with each item.
module spnb_div_pipe import spnb_pkg::*; #(
  parameter int QW     = FG_W,
  parameter int DEN_W  = W_W,
  parameter int BPS    = DIV_BPS,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  in_rem,
  input  logic [QW-1:0]     in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QW-1:0]     out_quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STAGES = QW / BPS;

  logic              v    [STAGES];
  logic [DEN_W-1:0]  rem  [STAGES];
  logic [DEN_W-1:0]  den  [STAGES];
  logic [QW-1:0]     nq   [STAGES];
  logic [SIDE_W-1:0] side [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic              s_v;
    logic [DEN_W-1:0]  s_rem;
    logic [DEN_W-1:0]  s_den;
    logic [QW-1:0]     s_nq;
    logic [SIDE_W-1:0] s_side;
    logic [DEN_W-1:0]  n_rem;
    logic [QW-1:0]     n_nq;

    // Stage source: the divider inputs or the previous stage.
    if (g == 0) begin : g_first
      assign s_v    = in_valid;
      assign s_rem  = in_rem;
      assign s_den  = in_den;
      assign s_nq   = in_num;
      assign s_side = in_side;
    end else begin : g_next
      assign s_v    = v[g-1];
      assign s_rem  = rem[g-1];
      assign s_den  = den[g-1];
      assign s_nq   = nq[g-1];
      assign s_side = side[g-1];
    end

    // BPS shift-and-subtract steps.
    always_comb begin
      logic [DEN_W:0] trial;
      n_rem = s_rem;
      n_nq  = s_nq;
      for (int j = 0; j < BPS; j++) begin
        trial = {n_rem, n_nq[QW-1]};
        if (trial >= {1'b0, s_den}) begin
          trial = trial - {1'b0, s_den};
          n_nq  = {n_nq[QW-2:0], 1'b1};
        end else begin
          n_nq  = {n_nq[QW-2:0], 1'b0};
        end
        n_rem = trial[DEN_W-1:0];
      end
    end

    // Valid bit of the stage.
    always_ff @(posedge clk) begin
      if (rst) begin
        v[g] <= 1'b0;
      end else if (en) begin
        v[g] <= s_v;
      end
    end

    // Stage payload.
    always_ff @(posedge clk) begin
      if (en) begin
        rem[g]  <= n_rem;
        den[g]  <= s_den;
        nq[g]   <= n_nq;
        side[g] <= s_side;
      end
    end
  end

  assign out_valid = v[STAGES-1];
  assign out_quo   = nq[STAGES-1];
  assign out_side  = side[STAGES-1];

endmodule

[rtl/core/stack_pixel_normalize_blend.sv]
// An accepted input passes the input, flag, divider, m0, m1, r and output registers
// before pixels.valid (two quotient bits per divider stage by default).
// Throughput: one pixel per clock; the two dividers are fully pipelined and the
// input stalls only when both entries of the output buffer are occupied.
// Reset (synchronous, active high) empties the pipeline and the output buffer and
// sets blend_enable to 0, blend_denominator to 1.0 and full_scale_select to 0.
module stack_pixel_normalize_blend import spnb_pkg::*; #(
  parameter int DIV_BITS_PER_STAGE = DIV_BPS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  spnb_in_if.sink               samples,
  spnb_out_if.source            pixels
);

  localparam int FG_SIDE_W  = WS_W + W_W + BG_W + 3;
  localparam int AVG_SIDE_W = BG_W + 3 + FG_W;

  // Configuration registers.
  logic           blend_enable;
  logic [W_W-1:0] blend_denominator;
  logic           full_scale_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_enable      <= 1'b0;
      blend_denominator <= BLEND_DEN_RESET;
      full_scale_select <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BLEND_ENABLE:      blend_enable      <= cfg_data[0];
        REG_BLEND_DENOMINATOR: blend_denominator <= cfg_data[W_W-1:0];
        REG_FULL_SCALE_SELECT: full_scale_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances while the skid entry is free.
  logic skid_valid;
  logic en;
  assign en            = !skid_valid;
  assign samples.ready = en;

  // Input register stage.
  logic            in_v;
  logic [WS_W-1:0] in_ws;
  logic [W_W-1:0]  in_w;
  logic [BG_W-1:0] in_bg;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (en) begin
      in_v <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_ws <= samples.weighted_sum;
      in_w  <= samples.weight_sum;
      in_bg <= samples.background;
    end
  end

  // Special cases: zero weights, saturated average (quotient of 2^40 or more),
  // foreground weight of one (weights at or above the denominator).
  logic            fl_v;
  logic [WS_W-1:0] fl_ws;
  logic [W_W-1:0]  fl_w;
  logic [BG_W-1:0] fl_bg;
  logic            fl_wz;
  logic            fl_sat;
  logic            fl_one;

  always_ff @(posedge clk) begin
    if (rst) begin
      fl_v <= 1'b0;
    end else if (en) begin
      fl_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl_ws  <= in_ws;
      fl_w   <= in_w;
      fl_bg  <= in_bg;
      fl_wz  <= (in_w == '0);
      fl_sat <= ({{(W_W + AVG_LO - WS_W){1'b0}}, in_ws} >= {in_w, {AVG_LO{1'b0}}});
      fl_one <= (in_w >= blend_denominator);
    end
  end

  // Foreground weight divider: weights * 2^16 / blend denominator.
  logic                 fd_v;
  logic [FG_W-1:0]      fd_q;
  logic [FG_SIDE_W-1:0] fd_side;
  logic [WS_W-1:0]      fd_ws;
  logic [W_W-1:0]       fd_w;
  logic [BG_W-1:0]      fd_bg;
  logic                 fd_wz;
  logic                 fd_sat;
  logic                 fd_one;

  spnb_div_pipe #(
    .QW     (FG_W),
    .DEN_W  (W_W),
    .BPS    (DIV_BITS_PER_STAGE),
    .SIDE_W (FG_SIDE_W)
  ) u_fg_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fl_v),
    .in_rem    (fl_w),
    .in_num    ({FG_W{1'b0}}),
    .in_den    (blend_denominator),
    .in_side   ({fl_ws, fl_w, fl_bg, fl_wz, fl_sat, fl_one}),
    .out_valid (fd_v),
    .out_quo   (fd_q),
    .out_side  (fd_side)
  );

  assign {fd_ws, fd_w, fd_bg, fd_wz, fd_sat, fd_one} = fd_side;

  // Average divider: weighted sum * 2^16 / weights.
  logic                  ad_v;
  logic [AVG_W-1:0]      ad_q;
  logic [AVG_SIDE_W-1:0] ad_side;
  logic [BG_W-1:0]       ad_bg;
  logic                  ad_wz;
  logic                  ad_sat;
  logic                  ad_one;
  logic [FG_W-1:0]       ad_fg;

  spnb_div_pipe #(
    .QW     (AVG_W),
    .DEN_W  (W_W),
    .BPS    (DIV_BITS_PER_STAGE),
    .SIDE_W (AVG_SIDE_W)
  ) u_avg_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fd_v),
    .in_rem    (W_W'(fd_ws[WS_W-1:AVG_LO])),
    .in_num    ({fd_ws[AVG_LO-1:0], {W_FRAC{1'b0}}}),
    .in_den    (fd_w),
    .in_side   ({fd_bg, fd_wz, fd_sat, fd_one, fd_q}),
    .out_valid (ad_v),
    .out_quo   (ad_q),
    .out_side  (ad_side)
  );

  assign {ad_bg, ad_wz, ad_sat, ad_one, ad_fg} = ad_side;

  // Resolve the average and the magnitude and sign of average minus background.
  logic [AVG_W-1:0] avg_c;
  logic             ge_c;

  always_comb begin
    if (ad_wz) begin
      avg_c = '0;
    end else if (ad_sat) begin
      avg_c = '1;
    end else begin
      avg_c = ad_q;
    end
    ge_c = (avg_c >= AVG_W'(ad_bg));
  end

  logic             m0_v;
  logic [AVG_W-1:0] m0_avg;
  logic [BG_W-1:0]  m0_bg;
  logic             m0_ge;
  logic [AVG_W-1:0] m0_mag;
  logic [FG_W-1:0]  m0_fg;
  logic             m0_one;

  always_ff @(posedge clk) begin
    if (rst) begin
      m0_v <= 1'b0;
    end else if (en) begin
      m0_v <= ad_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_avg <= avg_c;
      m0_bg  <= ad_bg;
      m0_ge  <= ge_c;
      m0_mag <= ge_c ? (avg_c - AVG_W'(ad_bg)) : (AVG_W'(ad_bg) - avg_c);
      m0_fg  <= ad_fg;
      m0_one <= ad_one;
    end
  end

  // Difference times the foreground weight (40 x 16 bits).
  logic             m1_v;
  logic [R_W-1:0]   m1_prod;
  logic [AVG_W-1:0] m1_avg;
  logic [BG_W-1:0]  m1_bg;
  logic             m1_ge;
  logic             m1_one;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (en) begin
      m1_v <= m0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_prod <= R_W'(m0_mag) * R_W'(m0_fg);
      m1_avg  <= m0_avg;
      m1_bg   <= m0_bg;
      m1_ge   <= m0_ge;
      m1_one  <= m0_one;
    end
  end

  // Blended value in Q.24. A weight of one, or no blending, gives the average.
  logic [R_W-1:0] bg_q24;
  logic [R_W-1:0] avg_q24;
  logic [R_W-1:0] r_next;
  logic           r_v;
  logic [R_W-1:0] r;

  assign bg_q24  = R_W'({m1_bg, {W_FRAC{1'b0}}});
  assign avg_q24 = {m1_avg, {W_FRAC{1'b0}}};

  always_comb begin
    if (!blend_enable || m1_one) begin
      r_next = avg_q24;
    end else if (m1_ge) begin
      r_next = bg_q24 + m1_prod;
    end else begin
      r_next = bg_q24 - m1_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else if (en) begin
      r_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r <= r_next;
    end
  end

  // Scale to 16 bits with rounding. For a full scale of 65535 the result is
  // (R + 2^23) >> 24; for 255 it is (257 R + 2^23) >> 24. Values at or above
  // full scale saturate.
  logic             sat16;
  logic             sat8;
  logic [RND_W-1:0] rnd16;
  logic [RND_W-1:0] rnd8;
  logic [PIX_W-1:0] pix_c;

  always_comb begin
    sat16 = (r >= TOP_16);
    sat8  = (r >= TOP_8);
    rnd16 = {1'b0, r[RND_W-2:0]} + ROUND_HALF;
    rnd8  = RND_W'(r[31:0]) + RND_W'({r[31:0], 8'h00}) + ROUND_HALF;
    if (full_scale_select) begin
      pix_c = sat8 ? PIX_MAX : rnd8[OUT_LO+PIX_W-1:OUT_LO];
    end else begin
      pix_c = sat16 ? PIX_MAX : rnd16[OUT_LO+PIX_W-1:OUT_LO];
    end
  end

  // Output register with a skid entry behind it.
  logic             out_valid;
  logic [PIX_W-1:0] out_pix;
  logic [PIX_W-1:0] skid_pix;
  logic             push;
  logic             take;

  assign push = en && r_v;
  assign take = out_valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid  <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_pix <= skid_pix;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_pix <= pix_c;
      end else begin
        out_pix  <= pix_c;
      end
    end
  end

  assign pixels.valid     = out_valid;
  assign pixels.pixel_out = out_pix;

  // The skid entry fills only when the output register held a result that was not taken.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(pixels.valid && !pixels.ready))
    else $error("skid entry filled while the output register was free");

  // A new result appears only when the last pipeline stage held an item.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pixels.valid) |-> $past(r_v))
    else $error("output became valid without an item in the last stage");

  // An accepted transaction lands in the input stage.
  a_in_capture: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> in_v)
    else $error("accepted transaction lost at the input stage");

endmodule
